[src/assert_macros.svh]
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is held
`define KJM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kjm assertion failed");

// next-cycle implication, off while reset is held
`define KJM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kjm assertion failed");

`endif

[src/kjm_pkg.sv]
`timescale 1ns / 1ps

package kjm_pkg;

    localparam int OP_W     = 2;
    localparam int IDX_W    = 3;
    localparam int MODE_W   = 2;
    localparam int LINE_W   = 8;
    localparam int MODS_W   = 4;
    localparam int PRESS_W  = 7;
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 8;

    // opcodes
    localparam logic [OP_W-1:0] OP_RD_A     = 2'd0;
    localparam logic [OP_W-1:0] OP_RD_B     = 2'd1;
    localparam logic [OP_W-1:0] OP_WR_ENTRY = 2'd2;
    localparam logic [OP_W-1:0] OP_SET_HELD = 2'd3;

    // entry modes, the spare code is stored but behaves as off
    localparam logic [MODE_W-1:0] MODE_OFF   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_JOY   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_KEY   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    // modifier matrix positions
    localparam logic [LINE_W-1:0] KEY_LSHIFT_A = 8'h02;
    localparam logic [LINE_W-1:0] KEY_LSHIFT_B = 8'h80;
    localparam logic [LINE_W-1:0] KEY_RSHIFT_A = 8'h40;
    localparam logic [LINE_W-1:0] KEY_RSHIFT_B = 8'h10;
    localparam logic [LINE_W-1:0] KEY_CMDR_A   = 8'h80;
    localparam logic [LINE_W-1:0] KEY_CMDR_B   = 8'h20;
    localparam logic [LINE_W-1:0] KEY_CTRL_A   = 8'h80;
    localparam logic [LINE_W-1:0] KEY_CTRL_B   = 8'h04;

    // bit order as in the held modifier field
    localparam logic [LINE_W-1:0] MOD_LINE_A [MODS_W] = '{
        KEY_LSHIFT_A, KEY_RSHIFT_A, KEY_CMDR_A, KEY_CTRL_A
    };
    localparam logic [LINE_W-1:0] MOD_LINE_B [MODS_W] = '{
        KEY_LSHIFT_B, KEY_RSHIFT_B, KEY_CMDR_B, KEY_CTRL_B
    };

    // table update command from the input stage
    typedef struct packed {
        logic                entry_we;
        logic                held_we;
        logic [IDX_W-1:0]    index;
        logic [MODE_W-1:0]   mode;
        logic [LINE_W-1:0]   mask_a;
        logic [LINE_W-1:0]   mask_b;
        logic [MODS_W-1:0]   mods;
    } t_tbl_wr;

    // port registers and read controls seen by the evaluator
    typedef struct packed {
        logic                port_b;
        logic                swap;
        logic                blocked;
        logic [PRESS_W-1:0]  pressed;
        logic [LINE_W-1:0]   data_a;
        logic [LINE_W-1:0]   dir_a;
        logic [LINE_W-1:0]   data_b;
        logic [LINE_W-1:0]   dir_b;
    } t_rd_req;

endpackage

[src/keyboard_joystick_matrix_port_read.sv]
// Keyboard and joystick matrix read port. Each transfer on the slave side is
// one command, chosen by s_axis_tuser: read port A, read port B, write one
// button table entry, or set the held key with its modifiers. Only the two
// reads return a transfer on the master side, carrying the 8-bit port value;
// the other commands update the table and return nothing. A read sees every
// table update whose command was accepted earlier. Throughput is one command
// per cycle while no read waits for a free output register: a command sits in
// the input register while all table entries, the held key and the four
// modifiers are evaluated side by side in one combinational pass, and a
// read's value lands in the output register, from which it is offered on the
// master side and transfers when m_axis_tready is high. The output
// register frees the input side: while a value waits for m_axis_tready, one
// more command can still be taken, and table updates keep flowing until the
// next read reaches the input register. The joystick swap bit is written
// through i_cfg_we / i_cfg_wdata and should only change while no command is
// in flight. BUTTONS sets the table depth; only the first seven buttons have
// pressed bits, and entry indexes beyond the table are ignored.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module keyboard_joystick_matrix_port_read import kjm_pkg::*; #(
    parameter int BUTTONS = 7
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration: bit 0 is the joystick swap flag
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // tdata, low bit up: entry_index[2:0], entry_mode[4:3], mask_a[12:5],
    // mask_b[20:13], key_mods[24:21], data_a[32:25], dir_a[40:33],
    // data_b[48:41], dir_b[56:49], buttons_pressed[63:57],
    // inputs_blocked[64], zero fill [71:65]
    input  logic [S_DATA_W-1:0] s_axis_tdata,
    // tuser: opcode[1:0]
    input  logic [OP_W-1:0]     s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // tdata: port_value[7:0]
    output logic [M_DATA_W-1:0] m_axis_tdata
);

    // joystick swap register
    logic r_swap;

    // input register
    logic                r_s1_valid;
    logic [OP_W-1:0]     r_s1_op;
    logic [S_DATA_W-1:0] r_s1_data;

    // output register
    logic                r_out_valid;
    logic [M_DATA_W-1:0] r_out_data;

    logic        s1_is_read;
    logic        out_free;
    logic        s1_go;
    t_tbl_wr     tbl_wr;
    t_rd_req     rd_req;
    logic [LINE_W-1:0] port_value;

    logic [MODE_W-1:0] tbl_mode   [BUTTONS];
    logic [LINE_W-1:0] tbl_mask_a [BUTTONS];
    logic [LINE_W-1:0] tbl_mask_b [BUTTONS];
    logic [LINE_W-1:0] held_a;
    logic [LINE_W-1:0] held_b;
    logic [MODS_W-1:0] held_mods;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swap <= 1'b0;
        end else if (i_cfg_we) begin
            r_swap <= i_cfg_wdata;
        end
    end

    // a read leaves the input register only into a free output register,
    // table updates leave at once
    assign s1_is_read    = (r_s1_op == OP_RD_A) || (r_s1_op == OP_RD_B);
    assign out_free      = !r_out_valid || m_axis_tready;
    assign s1_go         = r_s1_valid && (!s1_is_read || out_free);
    assign s_axis_tready = !r_s1_valid || s1_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_s1_op   <= s_axis_tuser;
            r_s1_data <= s_axis_tdata;
        end
    end

    // unpack the command fields
    always_comb begin
        tbl_wr.entry_we = s1_go && (r_s1_op == OP_WR_ENTRY);
        tbl_wr.held_we  = s1_go && (r_s1_op == OP_SET_HELD);
        tbl_wr.index    = r_s1_data[2:0];
        tbl_wr.mode     = r_s1_data[4:3];
        tbl_wr.mask_a   = r_s1_data[12:5];
        tbl_wr.mask_b   = r_s1_data[20:13];
        tbl_wr.mods     = r_s1_data[24:21];

        rd_req.port_b   = (r_s1_op == OP_RD_B);
        rd_req.swap     = r_swap;
        rd_req.data_a   = r_s1_data[32:25];
        rd_req.dir_a    = r_s1_data[40:33];
        rd_req.data_b   = r_s1_data[48:41];
        rd_req.dir_b    = r_s1_data[56:49];
        rd_req.pressed  = r_s1_data[63:57];
        rd_req.blocked  = r_s1_data[64];
    end

    kjm_button_table #(
        .BUTTONS     (BUTTONS)
    ) u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (tbl_wr),
        .o_mode      (tbl_mode),
        .o_mask_a    (tbl_mask_a),
        .o_mask_b    (tbl_mask_b),
        .o_held_a    (held_a),
        .o_held_b    (held_b),
        .o_held_mods (held_mods)
    );

    kjm_port_eval #(
        .BUTTONS     (BUTTONS)
    ) u_eval (
        .i_req       (rd_req),
        .i_mode      (tbl_mode),
        .i_mask_a    (tbl_mask_a),
        .i_mask_b    (tbl_mask_b),
        .i_held_a    (held_a),
        .i_held_b    (held_b),
        .i_held_mods (held_mods),
        .o_value     (port_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && s1_is_read) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && s1_is_read) begin
            r_out_data <= port_value;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // a read with room ahead shows up on the master side next cycle
    `KJM_ASSERT_NEXT(a_read_reaches_out, i_clk, i_rst_n,
        r_s1_valid && s1_is_read && out_free, m_axis_tvalid)

    // table updates never create a master transfer
    `KJM_ASSERT_NEXT(a_update_no_result, i_clk, i_rst_n,
        r_s1_valid && !s1_is_read && !r_out_valid, !m_axis_tvalid)

    // an empty input register always takes a command
    `KJM_ASSERT_NOW(a_empty_ready, i_clk, i_rst_n,
        !r_s1_valid, s_axis_tready)

endmodule

[src/kjm_button_table.sv]
`timescale 1ns / 1ps

module kjm_button_table import kjm_pkg::*; #(
    parameter int BUTTONS = 7
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_tbl_wr             i_wr,
    output logic [MODE_W-1:0]   o_mode   [BUTTONS],
    output logic [LINE_W-1:0]   o_mask_a [BUTTONS],
    output logic [LINE_W-1:0]   o_mask_b [BUTTONS],
    output logic [LINE_W-1:0]   o_held_a,
    output logic [LINE_W-1:0]   o_held_b,
    output logic [MODS_W-1:0]   o_held_mods
);

    logic [MODE_W-1:0] r_mode   [BUTTONS];
    logic [LINE_W-1:0] r_mask_a [BUTTONS];
    logic [LINE_W-1:0] r_mask_b [BUTTONS];
    logic [LINE_W-1:0] r_held_a;
    logic [LINE_W-1:0] r_held_b;
    logic [MODS_W-1:0] r_held_mods;

    // an index past the table matches no entry and is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < BUTTONS; i++) begin
                r_mode[i]   <= MODE_OFF;
                r_mask_a[i] <= '0;
                r_mask_b[i] <= '0;
            end
        end else if (i_wr.entry_we) begin
            for (int i = 0; i < BUTTONS; i++) begin
                if (32'(i_wr.index) == i) begin
                    r_mode[i]   <= i_wr.mode;
                    r_mask_a[i] <= i_wr.mask_a;
                    r_mask_b[i] <= i_wr.mask_b;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_a    <= '0;
            r_held_b    <= '0;
            r_held_mods <= '0;
        end else if (i_wr.held_we) begin
            r_held_a    <= i_wr.mask_a;
            r_held_b    <= i_wr.mask_b;
            r_held_mods <= i_wr.mods;
        end
    end

    assign o_mode      = r_mode;
    assign o_mask_a    = r_mask_a;
    assign o_mask_b    = r_mask_b;
    assign o_held_a    = r_held_a;
    assign o_held_b    = r_held_b;
    assign o_held_mods = r_held_mods;

endmodule

[src/kjm_port_eval.sv]
`timescale 1ns / 1ps

module kjm_port_eval import kjm_pkg::*; #(
    parameter int BUTTONS = 7
) (
    input  t_rd_req             i_req,
    input  logic [MODE_W-1:0]   i_mode   [BUTTONS],
    input  logic [LINE_W-1:0]   i_mask_a [BUTTONS],
    input  logic [LINE_W-1:0]   i_mask_b [BUTTONS],
    input  logic [LINE_W-1:0]   i_held_a,
    input  logic [LINE_W-1:0]   i_held_b,
    input  logic [MODS_W-1:0]   i_held_mods,
    output logic [LINE_W-1:0]   o_value
);

    logic [LINE_W-1:0] data_own, dir_own, data_oth, dir_oth;
    logic [LINE_W-1:0] base, filter, pull;
    logic [LINE_W-1:0] own, oth;
    logic              joy_here;
    logic              hit;

    always_comb begin
        data_own = i_req.port_b ? i_req.data_b : i_req.data_a;
        dir_own  = i_req.port_b ? i_req.dir_b  : i_req.dir_a;
        data_oth = i_req.port_b ? i_req.data_a : i_req.data_b;
        dir_oth  = i_req.port_b ? i_req.dir_a  : i_req.dir_b;
        joy_here = i_req.port_b ^ i_req.swap;
        base     = ~dir_own | (data_own & dir_own);
        // other port's driven-low lines select the columns
        filter   = ~data_oth & dir_oth;
        pull     = '0;

        for (int i = 0; i < BUTTONS; i++) begin
            own = i_req.port_b ? i_mask_b[i] : i_mask_a[i];
            oth = i_req.port_b ? i_mask_a[i] : i_mask_b[i];
            // buttons without a pressed bit never count
            hit = (i < PRESS_W) ? i_req.pressed[i % PRESS_W] : 1'b0;
            if (hit && !i_req.blocked) begin
                if (i_mode[i] == MODE_JOY) begin
                    if (joy_here) begin
                        pull = pull | i_mask_a[i];
                    end
                end else if (i_mode[i] == MODE_KEY) begin
                    if ((oth & filter) != '0) begin
                        pull = pull | own;
                    end
                end
            end
        end

        // held key ignores the block flag
        own = i_req.port_b ? i_held_b : i_held_a;
        oth = i_req.port_b ? i_held_a : i_held_b;
        if ((oth & filter) != '0) begin
            pull = pull | own;
        end

        for (int m = 0; m < MODS_W; m++) begin
            own = i_req.port_b ? MOD_LINE_B[m] : MOD_LINE_A[m];
            oth = i_req.port_b ? MOD_LINE_A[m] : MOD_LINE_B[m];
            if (i_held_mods[m] && ((oth & filter) != '0)) begin
                pull = pull | own;
            end
        end

        o_value = base & ~pull;
    end

endmodule
